@@ src/oss_pkg.sv @@
// Shared types and constants for the ordered set successor block.
`default_nettype none
package oss_pkg;

  // Default sizes of the key table.
  localparam int OSS_CAPACITY = 1024;
  localparam int OSS_KEY_BITS = 30;

  // Request codes carried by in_req_type.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NONE     = 2'd2,
    ST_FULL     = 2'd3
  } oss_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } oss_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } oss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } oss_sts_t;

endpackage
`default_nettype wire

@@ src/ordered_set_successor_top.sv @@
// Top level of the ordered set successor block.
`default_nettype none
// Holds up to CAPACITY distinct keys of KEY_BITS bits. An item either inserts
// a key (duplicates are ignored; a new key into a full table is dropped with
// status 3) or asks for the smallest stored key not less than the given key.
// Every item gives exactly one result. The table starts empty after reset.
// Items are handled one at a time: a new item is accepted only in the idle
// state, after the previous result has been loaded. The key memory has one read
// port, and each item scans every stored key through it one per cycle. The read
// port is registered, so each key is compared as it comes out; the controller
// then detects the end of the scan and loads the result into the output
// register once that register is free or is being emptied.
// A finished result waits in an output register while the next item is
// accepted and scanned.
module ordered_set_successor_top
  import oss_pkg::*;
#(
  parameter int CAPACITY = OSS_CAPACITY,
  parameter int KEY_BITS = OSS_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_req_type,
  input  wire logic [KEY_BITS-1:0] in_key,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [1:0]          out_status,
  output logic      [KEY_BITS-1:0] out_answer_key
);

  oss_cmd_t cmd;
  oss_sts_t sts;

  oss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  oss_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_answer_key (out_answer_key),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire

@@ src/oss_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module oss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the clock.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/oss_ctrl.sv @@
// Controller state machine that sequences accept, table scan and result.
`default_nettype none
module oss_ctrl
  import oss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire oss_sts_t sts,
  output oss_cmd_t      cmd
);

  oss_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/oss_dp.sv @@
// Datapath: key table, fill count, scan compare unit and result register.
`default_nettype none
module oss_dp
  import oss_pkg::*;
#(
  parameter int CAPACITY = OSS_CAPACITY,
  parameter int KEY_BITS = OSS_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_req_type,
  input  wire logic [KEY_BITS-1:0] in_key,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [1:0]          out_status,
  output logic      [KEY_BITS-1:0] out_answer_key,
  input  wire oss_cmd_t            cmd,
  output oss_sts_t                 sts
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // Request held for the duration of the scan.
  logic                req_type_r;
  logic [KEY_BITS-1:0] key_r;

  // Keys fill slots in order and are never removed, so a fill count
  // marks exactly which slots hold keys.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic             hit_r, hit_nxt;
  logic             dup_r, dup_nxt;
  logic [KEY_BITS-1:0] best_r, best_nxt;

  logic                out_valid_r, out_valid_nxt;
  oss_status_t         out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;

  logic                we;
  logic [KEY_BITS-1:0] rdata;
  logic                ge, better;

  oss_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (key_r),
    .raddr (issue_r[AW-1:0]),
    .rdata (rdata)
  );

  // Compare of the key read in the previous cycle against the request.
  assign ge     = (rdata >= key_r);
  assign better = ge && (!hit_r || (rdata < best_r));

  // Scan progress and running best candidate.
  always_comb begin
    issue_nxt = issue_r;
    pend_nxt  = pend_r;
    hit_nxt   = hit_r;
    dup_nxt   = dup_r;
    best_nxt  = best_r;
    if (cmd.start) begin
      issue_nxt = '0;
      pend_nxt  = 1'b0;
      hit_nxt   = 1'b0;
      dup_nxt   = 1'b0;
      best_nxt  = '0;
    end else if (cmd.scan) begin
      if (issue_r != count_r) begin
        issue_nxt = issue_r + CNT_W'(1);
        pend_nxt  = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r) begin
        if (rdata == key_r) begin
          dup_nxt = 1'b1;
        end
        if (better) begin
          hit_nxt  = 1'b1;
          best_nxt = rdata;
        end
      end
    end
  end

  assign sts.scan_done = !pend_r && (issue_r == count_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Result formation, table write and output handshake.
  always_comb begin
    count_nxt      = count_r;
    we             = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = '0;
      if (req_type_r == REQ_QUERY) begin
        if (hit_r) begin
          out_status_nxt = ST_FOUND;
          out_key_nxt    = best_r;
        end else begin
          out_status_nxt = ST_NONE;
        end
      end else if (dup_r) begin
        out_status_nxt = ST_INSERTED;
      end else if (count_r == CNT_FULL) begin
        out_status_nxt = ST_FULL;
      end else begin
        out_status_nxt = ST_INSERTED;
        we             = 1'b1;
        count_nxt      = count_r + CNT_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_type_r <= in_req_type;
      key_r      <= in_key;
    end
    hit_r        <= hit_nxt;
    dup_r        <= dup_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_answer_key = out_key_r;

endmodule
`default_nettype wire
